/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Every check is clocked on clk and switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hw/rtl/lcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock-order cycle checker package
// Sizes, status codes, sequencer states and beat types of the checker.
// ----------------------------------------------------------------------------
package lcc_pkg;

  // Number of distinct locks. The 4-bit lock number spans exactly this range.
  localparam int NUM_LOCKS   = 16;
  localparam int LOCK_IDX_W  = $clog2(NUM_LOCKS);
  // Entries in the stack of held locks.
  localparam int STACK_DEPTH = 16;
  localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

  // Fixed field widths of the beats.
  localparam int LOCK_ID_W   = 4;
  localparam int STATUS_W    = 3;
  localparam int DEPTH_W     = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_REL_EMPTY = 3'd1,
    ST_REL_ORDER = 3'd2,
    ST_CYCLE     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    MODE_ACQUIRE = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_EDGE,
    S_PICK,
    S_EXPAND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 mode;
    logic [LOCK_ID_W-1:0] lock_number;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [LOCK_ID_W-1:0] held_top;
    logic                 edge_added;
    logic [DEPTH_W-1:0]   stack_depth;
  } rsp_t;

endpackage

/* hw/rtl/lcc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/lock_order_cycle_checker_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Lock-order cycle checker
// Tracks held locks on a stack and records lock-order edges in an adjacency
// matrix; a new edge starts a reachability search that flags order cycles.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                      Beat
//   -------  ---------------------------  -----------------------------------
//   req      req_valid, req_ready, req    one lock event (mode, lock_number)
//   rsp      rsp_valid, rsp_ready, rsp    one result per event
//
// An event settled at the first step (a release, a faulted event, a full
// stack, or an acquire onto an empty stack or of the lock already on top)
// goes from the evaluate step straight to the result; an acquire whose order
// edge already exists passes through the edge check first. An acquire that
// records a new edge also walks the graph, a pick and an expand step for
// each lock expanded through the single read port of the order matrix.
// One event is in flight at a time: req_ready is high only in the idle state.
// A stalled result sits in the output register while the next event is
// already taken; the sequencer waits at its last step until that register
// frees. Reset clears the stack count, the fault code and the row valid
// bits at once, so the matrix reads as all zero right after reset.
//
module lock_order_cycle_checker_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lcc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lcc_pkg::rsp_t rsp
);

  import lcc_pkg::*;

  // Lowest set bit of a lock set; the search expands locks in that order.
  function automatic logic [LOCK_IDX_W-1:0] lowest_set(input logic [NUM_LOCKS-1:0] v);
    logic [LOCK_IDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = LOCK_IDX_W'(i);
      end
    end
    return idx;
  endfunction

  // Sequencer and control state.
  state_t                state;
  state_t                state_next;
  logic [COUNT_W-1:0]    held_count;
  status_t               fault;
  logic [NUM_LOCKS-1:0]  row_valid;

  // Latched event and working registers.
  logic                  mode_q;
  logic [LOCK_IDX_W-1:0] id_q;
  logic [LOCK_IDX_W-1:0] top_q;
  status_t               res_status;
  logic                  res_edge;
  logic [NUM_LOCKS-1:0]  visited;
  logic [NUM_LOCKS-1:0]  pending;
  logic                  rd_valid;
  logic [LOCK_IDX_W-1:0] held_stack [STACK_DEPTH];

  // Order matrix port.
  logic                  ram_we;
  logic [LOCK_IDX_W-1:0] ram_waddr;
  logic [NUM_LOCKS-1:0]  ram_wdata;
  logic [LOCK_IDX_W-1:0] ram_raddr;
  logic [NUM_LOCKS-1:0]  ram_rdata;

  // Decode of the latched event.
  logic                  is_release;
  logic                  stack_empty;
  logic                  stack_full;
  logic                  same_top;
  status_t               eval_status;
  logic                  eval_lookup;
  logic                  eval_pop;
  logic                  eval_push;

  // Search datapath.
  logic [NUM_LOCKS-1:0]  row_word;
  logic [NUM_LOCKS-1:0]  visited_next;
  logic                  reach_hit;
  logic [LOCK_IDX_W-1:0] pick_idx;
  logic                  edge_known;
  logic                  rsp_free;

  // Control strobes from the output decoder.
  logic                  do_push;
  logic                  do_pop;
  logic                  fault_load;
  status_t               fault_code;

  lcc_ram #(
    .WIDTH(NUM_LOCKS),
    .DEPTH(NUM_LOCKS)
  ) u_order_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // A row that was never written since reset reads as no edges.
  assign row_word     = ram_rdata & {NUM_LOCKS{rd_valid}};
  assign visited_next = visited | row_word;
  assign reach_hit    = visited_next[top_q];
  assign pick_idx     = lowest_set(pending);
  assign edge_known   = row_word[id_q];
  assign rsp_free     = !rsp_valid || rsp_ready;

  assign is_release  = (mode_q == MODE_RELEASE);
  assign stack_empty = (held_count == '0);
  assign stack_full  = (held_count >= COUNT_W'(STACK_DEPTH));
  assign same_top    = (top_q == id_q);

  // What the event does, judged from the stack and the fault code alone.
  always_comb begin
    eval_status = ST_OK;
    eval_lookup = 1'b0;
    eval_pop    = 1'b0;
    eval_push   = 1'b0;
    priority if (fault != ST_OK) begin
      eval_status = fault;
    end else if (is_release) begin
      priority if (stack_empty) begin
        eval_status = ST_REL_EMPTY;
      end else if (!same_top) begin
        eval_status = ST_REL_ORDER;
      end else begin
        eval_pop = 1'b1;
      end
    end else if (stack_full) begin
      eval_status = ST_FULL;
    end else if (!stack_empty && !same_top) begin
      eval_lookup = 1'b1;
    end else begin
      eval_push = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = eval_lookup ? S_EDGE : S_DONE;
      end
      S_EDGE: begin
        state_next = edge_known ? S_DONE : S_PICK;
      end
      S_PICK: begin
        state_next = (pending == '0) ? S_DONE : S_EXPAND;
      end
      S_EXPAND: begin
        state_next = reach_hit ? S_DONE : S_PICK;
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    req_ready  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = top_q;
    ram_wdata  = row_word | (NUM_LOCKS'(1) << id_q);
    ram_raddr  = pick_idx;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    fault_load = 1'b0;
    fault_code = ST_OK;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
      end
      S_EVAL: begin
        // Fetch the row of the top lock to see whether the edge exists.
        ram_raddr  = top_q;
        do_push    = eval_push;
        do_pop     = eval_pop;
        fault_load = (fault == ST_OK) && (eval_status != ST_OK);
        fault_code = eval_status;
      end
      S_EDGE: begin
        ram_we  = !edge_known;
        do_push = edge_known;
      end
      S_PICK: begin
        do_push = (pending == '0);
      end
      S_EXPAND: begin
        fault_load = reach_hit;
        fault_code = ST_CYCLE;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      fault      <= ST_OK;
      row_valid  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (do_push) begin
        held_count <= held_count + COUNT_W'(1);
      end else if (do_pop) begin
        held_count <= held_count - COUNT_W'(1);
      end
      if (fault_load) begin
        fault <= fault_code;
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_valid <= row_valid[ram_raddr];
    if (req_valid && req_ready) begin
      mode_q <= req.mode;
      id_q   <= LOCK_IDX_W'(req.lock_number);
      top_q  <= stack_empty ? '0 : held_stack[STACK_IDX_W'(held_count - COUNT_W'(1))];
    end
    if (do_push) begin
      held_stack[held_count[STACK_IDX_W-1:0]] <= id_q;
    end
    unique case (state)
      S_EVAL: begin
        res_status <= eval_status;
        res_edge   <= 1'b0;
      end
      S_EDGE: begin
        // The search starts from the new lock and looks for the old top.
        res_edge <= !edge_known;
        visited  <= NUM_LOCKS'(1) << id_q;
        pending  <= NUM_LOCKS'(1) << id_q;
      end
      S_PICK: begin
        pending[pick_idx] <= 1'b0;
      end
      S_EXPAND: begin
        visited <= visited_next;
        pending <= pending | (row_word & ~visited);
        if (reach_hit) begin
          res_status <= ST_CYCLE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp.status      <= res_status;
          rsp.held_top    <= LOCK_ID_W'(top_q);
          rsp.edge_added  <= res_edge;
          rsp.stack_depth <= DEPTH_W'(held_count);
        end
      end
      S_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  `ASSERT_NEVER(a_count_range, held_count > COUNT_W'(STACK_DEPTH),
                "held lock count beyond stack depth")
  `ASSERT_CLK(a_fault_sticky, fault != ST_OK |=> fault == $past(fault),
              "sticky fault code changed")
  `ASSERT_CLK(a_edge_status,
              rsp_valid && rsp.edge_added |-> rsp.status == ST_OK || rsp.status == ST_CYCLE,
              "edge reported with an unrelated status")
  `ASSERT_CLK(a_pending_visited,
              state == S_PICK || state == S_EXPAND |-> (pending & ~visited) == '0,
              "search frontier holds a lock not yet visited")

endmodule
